// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ----- src/imd_pkg.sv -----
// Shared constants for the integer matrix determinant block.
// No dependencies.
`default_nettype none
package imd_pkg;
    localparam int unsigned MaxSizeDefault = 8;
    localparam int unsigned SizeW = 4;
    localparam logic [SizeW-1:0] SizeReset = 4'd4;
    localparam int unsigned DataW = 32;
endpackage
`default_nettype wire

// ----- src/imd_core.sv -----
// Determinant engine: walks column subsets, minors kept in a memory.
// Depends on imd_pkg. Entries are read from the matrix memory in the top level.
`default_nettype none
module imd_core
    import imd_pkg::*;
#(
    parameter int unsigned MAX_SIZE = MaxSizeDefault,
    parameter int unsigned COLW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
    parameter int unsigned ADRW = (MAX_SIZE*MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [COLW:0]    i_n,
    output logic [ADRW-1:0]       o_ent_addr,
    input  wire logic [DataW-1:0] i_ent_data,
    output logic                  o_done,
    output logic [DataW-1:0]      o_det
);
    localparam int unsigned MCnt = 1 << MAX_SIZE;

    typedef enum logic [2:0] {S_IDLE, S_INIT, S_ISSUE, S_MUL, S_ACC, S_WB} t_state;

    t_state                r_state;
    logic [MAX_SIZE-1:0]   r_mask;
    logic [COLW:0]         r_j;
    logic [COLW:0]         r_row;
    logic                  r_neg;
    logic [DataW-1:0]      r_acc;
    logic [DataW-1:0]      r_prod;
    logic [DataW-1:0]      r_mrd;
    logic [DataW-1:0]      minor_mem [MCnt];
    logic [MAX_SIZE-1:0]   w_rd_addr;
    logic                  r_we;
    logic [MAX_SIZE-1:0]   r_wa;
    logic [DataW-1:0]      r_wd;
    logic [MAX_SIZE-1:0]   w_full;
    logic [MAX_SIZE-1:0]   w_bit;
    logic [COLW:0]         w_k;
    logic [2*ADRW+1:0]     w_lin;

    assign w_full = MAX_SIZE'((1 << i_n) - 1);
    assign w_bit  = MAX_SIZE'(1) << r_j[COLW-1:0];
    always_comb begin
        w_k = '0;
        for (int b = 0; b < MAX_SIZE; b++) w_k = w_k + (COLW+1)'(r_mask[b]);
    end
    assign w_lin = (2*ADRW+2)'(r_row) * (2*ADRW+2)'(i_n) + (2*ADRW+2)'(r_j);
    assign o_ent_addr = w_lin[ADRW-1:0];
    assign w_rd_addr  = r_mask & ~w_bit;

    always_ff @(posedge i_clk) begin
        if (r_we) minor_mem[r_wa] <= r_wd;
        r_mrd <= minor_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_we    <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_we   <= ((r_state == S_IDLE) && i_start) || (r_state == S_WB);
            o_done <= (r_state == S_WB) && (r_mask == w_full);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_wa    <= '0;
                        r_wd    <= DataW'(1);
                        r_mask  <= MAX_SIZE'(1);
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_neg   <= 1'b0;
                    r_row   <= i_n - w_k;
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (r_j == i_n) begin
                        r_state <= S_WB;
                    end else if ((r_mask & w_bit) != '0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_MUL: begin
                    r_prod  <= i_ent_data * r_mrd;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_neg ? r_acc - r_prod : r_acc + r_prod;
                    r_neg   <= ~r_neg;
                    r_j     <= r_j + 1'b1;
                    r_state <= S_ISSUE;
                end
                S_WB: begin
                    r_wa <= r_mask;
                    r_wd <= r_acc;
                    if (r_mask == w_full) begin
                        o_det   <= r_acc;
                        r_state <= S_IDLE;
                    end else begin
                        r_mask  <= r_mask + 1'b1;
                        r_state <= S_INIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- src/integer_matrix_determinant.sv -----
// Integer matrix determinant, top level: entry loading, matrix memory, output register.
// Depends on imd_pkg and imd_core.
//
// Input channel: one 32-bit entry word per accepted handshake (i_valid high,
// o_stall low), row-major. Side length n comes from i_cfg_we/i_cfg_data;
// 0 acts as 1, values above MAX_SIZE saturate; a write restarts loading.
// Entries load at one per cycle while o_stall is low. After the last
// of n*n entries the engine walks all 2^n-1 column subsets; for each
// subset of k columns it spends one scan step per column, two more per
// member column, plus setup and write-back, on one shared 32x32
// multiplier and one minor memory read port. o_stall stays high
// throughout the expansion.
// The determinant word is held in an output register until taken
// (o_valid high, i_stall low); a new matrix loads while it waits, but its
// expansion starts only after the old word is taken.
// Reset (synchronous, active low) sets n to 4 and empties the count and
// the output register; the matrix memory is not cleared.
`default_nettype none
module integer_matrix_determinant
    import imd_pkg::*;
#(
    parameter int unsigned MAX_SIZE = MaxSizeDefault
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [DataW-1:0] i_entry_value,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [DataW-1:0]      o_determinant,
    input  wire logic                    i_cfg_we,
    input  wire logic [SizeW-1:0]        i_cfg_data
);
    localparam int unsigned Depth = MAX_SIZE * MAX_SIZE;
    localparam int unsigned ADRW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned COLW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int unsigned CNTW = ADRW + 1;

    logic [SizeW-1:0]  r_size;
    logic [CNTW-1:0]   r_count;
    logic              r_pend;
    logic              r_busy;
    logic [COLW:0]     w_n;
    logic [CNTW-1:0]   w_total;
    logic              w_acc;
    logic              w_last;
    logic [ADRW-1:0]   w_ent_addr;
    logic [DataW-1:0]  r_ent_rd;
    logic [DataW-1:0]  mat_mem [Depth];
    logic              w_done;
    logic [DataW-1:0]  w_det;
    logic              w_start;

    always_comb begin
        if (r_size == '0) w_n = (COLW+1)'(1);
        else if (32'(r_size) > MAX_SIZE) w_n = (COLW+1)'(MAX_SIZE);
        else w_n = (COLW+1)'(r_size);
    end
    assign w_total = CNTW'(w_n) * CNTW'(w_n);
    assign o_stall = r_busy | r_pend;
    assign w_acc   = i_valid & ~o_stall;
    assign w_last  = w_acc & (r_count + 1'b1 == w_total);
    assign w_start = r_pend & ~r_busy & ~o_valid;

    always_ff @(posedge i_clk) begin
        if (w_acc) mat_mem[r_count[ADRW-1:0]] <= i_entry_value;
        r_ent_rd <= mat_mem[w_ent_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SizeReset;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size  <= i_cfg_data;
                r_count <= '0;
            end else if (w_acc) begin
                r_count <= w_last ? '0 : r_count + 1'b1;
            end
            if (w_last) r_pend <= 1'b1;
            if (w_start) begin
                r_pend <= 1'b0;
                r_busy <= 1'b1;
            end
            if (w_done) begin
                r_busy        <= 1'b0;
                o_valid       <= 1'b1;
                o_determinant <= w_det;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    imd_core #(.MAX_SIZE(MAX_SIZE)) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_n       (w_n),
        .o_ent_addr(w_ent_addr),
        .i_ent_data(r_ent_rd),
        .o_done    (w_done),
        .o_det     (w_det)
    );
endmodule
`default_nettype wire

// ----- src/imd_checker.sv -----
// Port-level checker for integer_matrix_determinant, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module imd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_determinant
);
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_determinant))
    `CHK_NEXT(a_busy_no_rise, i_clk, i_rst_n, o_valid && i_stall, !$rose(o_valid))
    `CHK_IMPL(a_new_word_stalled, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))
endmodule
bind integer_matrix_determinant imd_checker u_imd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_determinant(o_determinant)
);
`default_nettype wire

// ----- test/tb_integer_matrix_determinant.sv -----
// Testbench for integer_matrix_determinant: streams matrices and checks every determinant word.
// Depends on imd_pkg and the integer_matrix_determinant RTL.
`default_nettype none
module tb_integer_matrix_determinant;
    import imd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxN = 8;
    localparam int StallLimit = 40000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [DataW-1:0] i_entry_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [DataW-1:0] o_determinant;
    logic i_cfg_we = 1'b0;
    logic [SizeW-1:0] i_cfg_data = '0;

    integer_matrix_determinant i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_entry_value(i_entry_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_determinant(o_determinant),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [SizeW-1:0] size_reg = SizeReset;
    logic [DataW-1:0] entries [MaxN*MaxN];
    int entry_cnt = 0;
    logic [DataW-1:0] det_queue [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_start = 1'b0;
    int hold_len = 0;
    int mismatches = 0;
    bit failed = 1'b0;

    function automatic int side_of(logic [SizeW-1:0] s);
        if (s == 0) return 1;
        if (s > MaxN) return MaxN;
        return int'(s);
    endfunction

    // determinant by minors over column subsets of the bottom rows, wrapping at 32 bits
    function automatic logic [DataW-1:0] expand_det(int n);
        logic [DataW-1:0] minor [1 << MaxN];
        logic [DataW-1:0] acc;
        logic [DataW-1:0] term;
        int k;
        int pos;
        minor[0] = DataW'(1);
        for (int m = 1; m < (1 << n); m++) begin
            k = $countones(m);
            acc = '0;
            pos = 0;
            for (int j = 0; j < n; j++) begin
                if (m[j]) begin
                    term = entries[(n - k) * n + j] * minor[m & ~(1 << j)];
                    acc = pos[0] ? acc - term : acc + term;
                    pos++;
                end
            end
            minor[m] = acc;
        end
        return minor[(1 << n) - 1];
    endfunction

    task automatic send_word(logic [DataW-1:0] v);
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_entry_value <= v;
        do @(posedge i_clk); while (o_stall);
        n = side_of(size_reg);
        entries[entry_cnt] = v;
        entry_cnt++;
        if (entry_cnt == n * n) begin
            det_queue.push_back(expand_det(n));
            entry_cnt = 0;
        end
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        stop_sending();
        while (det_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SizeW-1:0] s);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = s;
        entry_cnt = 0;
    endtask

    function automatic logic [DataW-1:0] rand_entry();
        case ($urandom_range(5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(6) - 3;
        endcase
    endfunction

    task automatic send_matrix(int n);
        for (int i = 0; i < n * n; i++) send_word(rand_entry());
    endtask

    task automatic test_extremes();
        write_size(1);
        send_word(32'h7fff_ffff);
        send_word(32'h8000_0000);
        send_word(32'h0);
        send_word(32'hffff_ffff);
        write_size(2);
        send_word(32'h8000_0000); send_word(32'h7fff_ffff);
        send_word(32'h7fff_ffff); send_word(32'h8000_0000);
        write_size(0);
        send_word(32'h1234_5678);
        write_size(3);
        send_matrix(3);
    endtask

    task automatic test_size_saturates();
        write_size(4'hf);
        send_matrix(8);
        write_size(8);
        send_matrix(8);
    endtask

    task automatic test_restart_midmatrix();
        write_size(3);
        repeat (5) send_word($urandom);
        write_size(2);
        send_word(32'd1); send_word(32'd2); send_word(32'd3); send_word(32'd4);
        write_size(4);
        repeat (3) send_word($urandom);
        write_size(4);
        send_matrix(4);
    endtask

    task automatic test_random(int idle_pct, int stall_pct, int words);
        int sent;
        int n;
        logic [SizeW-1:0] s;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < words) begin
            s = ($urandom_range(19) == 0) ? SizeW'($urandom_range(15)) :
                SizeW'($urandom_range(1, 5));
            write_size(s);
            n = side_of(s);
            repeat ((n > 5) ? 1 : $urandom_range(1, 6)) begin
                send_matrix(n);
                sent += n * n;
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_size(2);
        hold_start = 1'b1;
        repeat (12) send_matrix(2);
        drain();
        send_matrix(2);
        send_matrix(2);
        drain();
    endtask

    // result side: random stall, long hold-off on request, and the comparison
    always @(posedge i_clk) begin
        if (o_valid && !i_stall && i_rst_n) begin
            if (det_queue.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_determinant);
            end else begin
                if (o_determinant !== det_queue[0]) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("determinant exp %h got %h", det_queue[0], o_determinant);
                end
                void'(det_queue.pop_front());
            end
        end
        if (hold_start) begin
            hold_start = 1'b0;
            hold_len = 600;
        end
        if (hold_len > 0) hold_len--;
        i_stall <= (hold_len > 0) || ($urandom_range(99) < recv_stall_pct);
    end

    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_size_saturates();
        test_restart_midmatrix();
        test_backpressure();
        test_random(0, 0, 130);
        test_random(81, 0, 130);
        test_random(0, 81, 130);
        test_random(6, 6, 130);
        drain();
        repeat (50) @(posedge i_clk);
        if (!failed && det_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+src
src/imd_pkg.sv
src/imd_core.sv
src/integer_matrix_determinant.sv
src/imd_checker.sv
test/tb_integer_matrix_determinant.sv
